// ===== rtl/config_text_tokenizer_top_defines.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctt_pkg.sv =====
// Types, constants and character helpers of the configuration text tokenizer.
package ctt_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int OUT_OFF_W   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TDATA_W     = 80;

    localparam logic [15:0] MAX16 = 16'hFFFF;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [4:0] {
        KIND_IDENT     = 5'd0,
        KIND_NUMBER    = 5'd1,
        KIND_QUOTE     = 5'd2,
        KIND_LPAREN    = 5'd3,
        KIND_RPAREN    = 5'd4,
        KIND_LBRACE    = 5'd5,
        KIND_RBRACE    = 5'd6,
        KIND_COMMA     = 5'd7,
        KIND_DOT       = 5'd8,
        KIND_EQUAL     = 5'd9,
        KIND_SEMI      = 5'd10,
        KIND_PERCENT   = 5'd11,
        KIND_DOLLAR    = 5'd12,
        KIND_STAR      = 5'd13,
        KIND_BACKSLASH = 5'd14,
        KIND_NEWLINE   = 5'd15,
        KIND_REMARK    = 5'd16,
        KIND_END       = 5'd17,
        KIND_UNKNOWN   = 5'd18,
        KIND_UNTERM    = 5'd19
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_QUOTE  = 3'd2,
        MODE_REMARK = 3'd3,
        MODE_ERROR  = 3'd4
    } lex_mode_t;

    typedef enum logic [1:0] {
        EOL_NONE = 2'd0,
        EOL_CR   = 2'd1,
        EOL_LF   = 2'd2
    } eol_t;

    typedef struct packed {
        token_kind_t          kind;
        logic [15:0]          line;
        logic [15:0]          column;
        logic [OUT_OFF_W-1:0] offset;
        logic [15:0]          length;
    } token_t;

    // Up to two tokens caused by one input item.
    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } step_result_t;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == MAX16) ? v : v + 16'd1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_digit(b) || is_alpha(b) || (b == CH_UNDER);
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    // Returns the punctuation kind, or KIND_UNKNOWN for any other byte.
    function automatic token_kind_t punct_kind(input logic [7:0] b);
        token_kind_t k;
        case (b)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2C:   k = KIND_COMMA;
            8'h2E:   k = KIND_DOT;
            8'h3D:   k = KIND_EQUAL;
            8'h3B:   k = KIND_SEMI;
            8'h25:   k = KIND_PERCENT;
            8'h24:   k = KIND_DOLLAR;
            8'h2A:   k = KIND_STAR;
            8'h5C:   k = KIND_BACKSLASH;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/ctt_front.sv =====
// Front end: accepts text bytes, keeps the lexer state and forms the tokens of each byte.
`include "config_text_tokenizer_top_defines.svh"

module ctt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // text_byte[7:0]
    input  logic                  s_tlast,   // end_of_text
    input  logic                  q_full,
    output logic                  push,
    output ctt_pkg::step_result_t push_data
);

    ctt_pkg::lex_mode_t mode_reg, mode_next;
    ctt_pkg::eol_t      peol_reg, peol_next;
    logic [15:0] line_reg, line_next, col_reg, col_next;
    logic [ctt_pkg::OFFSET_BITS-1:0] off_reg, off_next, poff_reg, poff_next;
    logic [15:0] pline_reg, pline_next, pcol_reg, pcol_next, plen_reg, plen_next;
    logic        pnum_reg, pnum_next;

    logic              accept;
    logic [1:0]        cnt;
    ctt_pkg::token_t   tok [2];
    ctt_pkg::token_t   pend_tok;
    ctt_pkg::token_t   new_tok;
    logic              do_idle;
    logic              absorb;
    logic [7:0]        b;

    assign b        = s_tdata;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        pend_tok.kind   = ctt_pkg::KIND_IDENT;
        pend_tok.line   = pline_reg;
        pend_tok.column = pcol_reg;
        pend_tok.offset = ctt_pkg::OUT_OFF_W'(poff_reg);
        pend_tok.length = plen_reg;
    end

    always_comb begin
        mode_next  = mode_reg;
        peol_next  = peol_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        pline_next = pline_reg;
        pcol_next  = pcol_reg;
        poff_next  = poff_reg;
        plen_next  = plen_reg;
        pnum_next  = pnum_reg;
        cnt        = 2'd0;
        tok[0]     = '0;
        tok[1]     = '0;
        new_tok    = '0;
        do_idle    = 1'b0;
        absorb     = 1'b0;

        if (accept) begin
            if (s_tlast) begin
                case (mode_reg)
                    ctt_pkg::MODE_WORD: begin
                        tok[0]      = pend_tok;
                        tok[0].kind = pnum_reg ? ctt_pkg::KIND_NUMBER : ctt_pkg::KIND_IDENT;
                        cnt         = 2'd1;
                    end
                    ctt_pkg::MODE_QUOTE: begin
                        tok[0]      = pend_tok;
                        tok[0].kind = ctt_pkg::KIND_UNTERM;
                        cnt         = 2'd1;
                    end
                    ctt_pkg::MODE_REMARK: begin
                        tok[0]      = pend_tok;
                        tok[0].kind = ctt_pkg::KIND_REMARK;
                        cnt         = 2'd1;
                    end
                    default: begin
                    end
                endcase
                new_tok.kind    = ctt_pkg::KIND_END;
                new_tok.line    = line_reg;
                new_tok.column  = col_reg;
                new_tok.offset  = ctt_pkg::OUT_OFF_W'(off_reg);
                new_tok.length  = 16'd0;
                tok[cnt[0]]     = new_tok;
                cnt             = cnt + 2'd1;
                mode_next  = ctt_pkg::MODE_IDLE;
                peol_next  = ctt_pkg::EOL_NONE;
                line_next  = 16'd1;
                col_next   = 16'd1;
                off_next   = '0;
                pline_next = '0;
                pcol_next  = '0;
                poff_next  = '0;
                plen_next  = '0;
                pnum_next  = 1'b0;
            end else begin
                peol_next = ctt_pkg::EOL_NONE;
                absorb = ((b == ctt_pkg::CH_CR) && (peol_reg == ctt_pkg::EOL_LF)) ||
                         ((b == ctt_pkg::CH_LF) && (peol_reg == ctt_pkg::EOL_CR));
                if (!absorb) begin
                    case (mode_reg)
                        ctt_pkg::MODE_ERROR: begin
                        end
                        ctt_pkg::MODE_WORD: begin
                            if (ctt_pkg::is_word(b)) begin
                                if (!ctt_pkg::is_digit(b)) begin
                                    pnum_next = 1'b0;
                                end
                                plen_next = ctt_pkg::inc16(plen_reg);
                                col_next  = ctt_pkg::inc16(col_reg);
                            end else begin
                                tok[0]      = pend_tok;
                                tok[0].kind = pnum_reg ? ctt_pkg::KIND_NUMBER
                                                       : ctt_pkg::KIND_IDENT;
                                cnt         = 2'd1;
                                do_idle     = 1'b1;
                            end
                        end
                        ctt_pkg::MODE_QUOTE: begin
                            if (b == ctt_pkg::CH_QUOTE) begin
                                col_next    = ctt_pkg::inc16(col_reg);
                                tok[0]      = pend_tok;
                                tok[0].kind = ctt_pkg::KIND_QUOTE;
                                cnt         = 2'd1;
                                mode_next   = ctt_pkg::MODE_IDLE;
                            end else if (ctt_pkg::is_eol(b)) begin
                                tok[0]      = pend_tok;
                                tok[0].kind = ctt_pkg::KIND_UNTERM;
                                cnt         = 2'd1;
                                mode_next   = ctt_pkg::MODE_ERROR;
                            end else begin
                                plen_next = ctt_pkg::inc16(plen_reg);
                                col_next  = ctt_pkg::inc16(col_reg);
                            end
                        end
                        ctt_pkg::MODE_REMARK: begin
                            if (ctt_pkg::is_eol(b)) begin
                                tok[0]      = pend_tok;
                                tok[0].kind = ctt_pkg::KIND_REMARK;
                                cnt         = 2'd1;
                                do_idle     = 1'b1;
                            end else begin
                                plen_next = ctt_pkg::inc16(plen_reg);
                                col_next  = ctt_pkg::inc16(col_reg);
                            end
                        end
                        default: begin
                            do_idle = 1'b1;
                        end
                    endcase

                    if (do_idle) begin
                        mode_next      = ctt_pkg::MODE_IDLE;
                        new_tok.line   = line_reg;
                        new_tok.column = col_reg;
                        new_tok.offset = ctt_pkg::OUT_OFF_W'(off_reg);
                        if (ctt_pkg::is_blank(b)) begin
                            col_next = ctt_pkg::inc16(col_reg);
                        end else if (ctt_pkg::is_word(b)) begin
                            pline_next = line_reg;
                            pcol_next  = col_reg;
                            poff_next  = off_reg;
                            plen_next  = 16'd1;
                            pnum_next  = ctt_pkg::is_digit(b);
                            mode_next  = ctt_pkg::MODE_WORD;
                            col_next   = ctt_pkg::inc16(col_reg);
                        end else if (ctt_pkg::is_eol(b)) begin
                            new_tok.kind   = ctt_pkg::KIND_NEWLINE;
                            new_tok.length = 16'd1;
                            tok[cnt[0]]    = new_tok;
                            cnt            = cnt + 2'd1;
                            col_next       = 16'd1;
                            line_next      = ctt_pkg::inc16(line_reg);
                            peol_next      = (b == ctt_pkg::CH_CR) ? ctt_pkg::EOL_CR
                                                                   : ctt_pkg::EOL_LF;
                        end else if ((b == ctt_pkg::CH_QUOTE) || (b == ctt_pkg::CH_HASH)) begin
                            pline_next = line_reg;
                            pcol_next  = col_reg;
                            poff_next  = ctt_pkg::inc_off(off_reg);
                            plen_next  = 16'd0;
                            mode_next  = (b == ctt_pkg::CH_QUOTE) ? ctt_pkg::MODE_QUOTE
                                                                  : ctt_pkg::MODE_REMARK;
                            col_next   = ctt_pkg::inc16(col_reg);
                        end else if (ctt_pkg::punct_kind(b) != ctt_pkg::KIND_UNKNOWN) begin
                            new_tok.kind   = ctt_pkg::punct_kind(b);
                            new_tok.length = 16'd1;
                            tok[cnt[0]]    = new_tok;
                            cnt            = cnt + 2'd1;
                            col_next       = ctt_pkg::inc16(col_reg);
                        end else begin
                            new_tok.kind   = ctt_pkg::KIND_UNKNOWN;
                            new_tok.length = 16'd0;
                            tok[cnt[0]]    = new_tok;
                            cnt            = cnt + 2'd1;
                            mode_next      = ctt_pkg::MODE_ERROR;
                        end
                    end
                end
                off_next = ctt_pkg::inc_off(off_reg);
            end
        end
    end

    assign push           = accept && (cnt != 2'd0);
    assign push_data.tok0 = tok[0];
    assign push_data.tok1 = tok[1];
    assign push_data.two  = cnt[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ctt_pkg::MODE_IDLE;
            peol_reg <= ctt_pkg::EOL_NONE;
            line_reg <= 16'd1;
            col_reg  <= 16'd1;
            off_reg  <= '0;
            pline_reg <= '0;
            pcol_reg  <= '0;
            poff_reg  <= '0;
            plen_reg  <= '0;
            pnum_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            peol_reg  <= peol_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            pline_reg <= pline_next;
            pcol_reg  <= pcol_next;
            poff_reg  <= poff_next;
            plen_reg  <= plen_next;
            pnum_reg  <= pnum_next;
        end
    end

    `CTT_ASSERT_IMPL(a_error_quiet, aclk, aresetn, accept && !s_tlast && (mode_reg == ctt_pkg::MODE_ERROR), !push, "byte in error mode produced a token")
    `CTT_ASSERT_NEXT(a_end_rearms, aclk, aresetn, accept && s_tlast, (mode_reg == ctt_pkg::MODE_IDLE) && (line_reg == 16'd1) && (off_reg == '0), "end marker did not re-arm the lexer")

endmodule

// ===== rtl/ctt_queue.sv =====
// Short queue of per-byte token groups between the front end and the output stage.
`include "config_text_tokenizer_top_defines.svh"

module ctt_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ctt_pkg::step_result_t push_data,
    output logic                  full,
    input  logic                  pop,
    output ctt_pkg::step_result_t pop_data,
    output logic                  empty
);

    ctt_pkg::step_result_t mem [ctt_pkg::QUEUE_DEPTH];
    logic [ctt_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ctt_pkg::QCNT_W-1:0] count_reg;

    assign full     = (count_reg == ctt_pkg::QCNT_W'(ctt_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CTT_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full || pop, "push into a full queue")
    `CTT_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not follow a push")

endmodule

// ===== rtl/ctt_back.sv =====
// Output stage: holds one token group and hands its tokens to the result channel.
`include "config_text_tokenizer_top_defines.svh"

module ctt_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  ctt_pkg::step_result_t             q_data,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ctt_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tlast
);

    ctt_pkg::step_result_t cur_reg;
    logic                  valid_reg;
    logic                  idx_reg;
    logic                  last_now;
    ctt_pkg::token_t       tok;

    assign last_now = idx_reg || !cur_reg.two;
    assign tok      = idx_reg ? cur_reg.tok1 : cur_reg.tok0;
    assign m_tvalid = valid_reg;
    assign m_tlast  = last_now;
    assign m_tdata  = {3'd0, tok.length, tok.offset, tok.column, tok.line, tok.kind};
    assign q_pop    = !q_empty && (!valid_reg || (m_tready && last_now));

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end else if (valid_reg && m_tready) begin
            if (last_now) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= 1'b1;
            end
        end
    end

    `CTT_ASSERT_IMPL(a_second_only_in_pair, aclk, aresetn, valid_reg && idx_reg, cur_reg.two, "second token shown for a single-token group")

endmodule

// ===== rtl/config_text_tokenizer_top.sv =====
// Top level of the configuration text tokenizer.
//
//  Channel | Direction | Carries
//  s_      | in        | tdata[7:0] text_byte, tlast end_of_text
//  m_      | out       | tdata token fields, tlast last_of_step
//
// One byte is accepted per cycle while the queue is not full; each accepted byte updates the registered lexer state.
// A byte that causes two tokens hands them to the result channel one after the other.
// Results pass through the queue and then the output stage register before they appear.
// The four-entry queue lets bytes keep coming while the result side stalls.
// Reset is synchronous, active low, and leaves the lexer at line 1, column 1.
module config_text_tokenizer_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // text_byte[7:0]
    input  logic                        s_tlast,   // end_of_text
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // token_kind[4:0], start_line[20:5], start_column[36:21],
    // content_offset[60:37], content_length[76:61], zero fill[79:77]
    output logic [ctt_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast    // last_of_step
);

    logic                  push, q_full, q_pop, q_empty;
    ctt_pkg::step_result_t push_data, q_data;

    ctt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    ctt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    ctt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
